/* hdl/cld_pkg.sv */
// cld_pkg: shared constants, types and helpers for the line discipline
// no dependencies; imported by every module of the block
`default_nettype none

package cld_pkg;

  // store sizes
  localparam int RING_DEPTH = 256;
  localparam int LINE_DEPTH = 128;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_CW    = $clog2(RING_DEPTH + 1);
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LINE_CW    = $clog2(LINE_DEPTH + 1);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_UPPER_C = 8'h43;

  // register reset values
  localparam logic [7:0] INTR_CHAR_RESET  = 8'd3;
  localparam logic [7:0] ERASE_CHAR_RESET = 8'd127;

  // input word operations
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ECHO_ENABLE  = 3'd0,
    REG_CANONICAL    = 3'd1,
    REG_CRNL_ENABLE  = 3'd2,
    REG_ISIG_ENABLE  = 3'd3,
    REG_NOFLUSH      = 3'd4,
    REG_ECHO_CTL     = 3'd5,
    REG_INTR_CHAR    = 3'd6,
    REG_ERASE_CHAR   = 3'd7
  } reg_index_t;

  // item classes decided by the front
  typedef enum logic [1:0] {
    CMD_POP   = 2'd0,
    CMD_INTR  = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_CHAR  = 2'd3
  } cmd_kind_t;

  // echo sequences produced by the back
  typedef enum logic [2:0] {
    ECHO_NONE   = 3'd0,
    ECHO_SINGLE = 3'd1,
    ECHO_CRLF   = 3'd2,
    ECHO_ERASE  = 3'd3,
    ECHO_INTR   = 3'd4
  } echo_kind_t;

  // one classified word with the settings it needs
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic       canon;
    logic       echo_en;
    logic       echo_ctl;
    logic       flush;
  } cmd_t;

  // byte at position idx of an echo sequence
  function automatic logic [7:0] echo_byte(echo_kind_t kind, logic [1:0] idx,
                                           logic [7:0] ch);
    logic [7:0] b;
    b = CH_NUL;
    unique case (kind)
      ECHO_SINGLE: b = ch;
      ECHO_CRLF:   b = (idx == 2'd0) ? CH_CR : CH_LF;
      ECHO_ERASE:  b = (idx == 2'd1) ? CH_SP : CH_BS;
      ECHO_INTR: begin
        unique case (idx)
          2'd0: b = CH_CARET;
          2'd1: b = CH_UPPER_C;
          2'd2: b = CH_CR;
          2'd3: b = CH_LF;
        endcase
      end
      default:     b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hdl/cld_front.sv */
// cld_front: configuration registers, input word accept and classification
// depends on cld_pkg; feeds cld_cmdq
`default_nettype none

module cld_front import cld_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [7:0] rx_char,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic            q_push,
  output cmd_t            q_cmd,
  input  wire logic       q_ready
);

  logic       echo_enable;
  logic       canonical_mode;
  logic       crnl_enable;
  logic       isig_enable;
  logic       noflush_on_intr;
  logic       echo_ctl;
  logic [7:0] intr_char;
  logic [7:0] erase_char;
  logic [7:0] ch;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable     <= 1'b1;
      canonical_mode  <= 1'b1;
      crnl_enable     <= 1'b1;
      isig_enable     <= 1'b1;
      noflush_on_intr <= 1'b0;
      echo_ctl        <= 1'b1;
      intr_char       <= INTR_CHAR_RESET;
      erase_char      <= ERASE_CHAR_RESET;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_ECHO_ENABLE: echo_enable     <= cfg_data[0];
        REG_CANONICAL:   canonical_mode  <= cfg_data[0];
        REG_CRNL_ENABLE: crnl_enable     <= cfg_data[0];
        REG_ISIG_ENABLE: isig_enable     <= cfg_data[0];
        REG_NOFLUSH:     noflush_on_intr <= cfg_data[0];
        REG_ECHO_CTL:    echo_ctl        <= cfg_data[0];
        REG_INTR_CHAR:   intr_char       <= cfg_data;
        REG_ERASE_CHAR:  erase_char      <= cfg_data;
      endcase
    end
  end

  // cr to lf translation
  assign ch = (crnl_enable && rx_char == CH_CR) ? CH_LF : rx_char;

  // classify the word
  always_comb begin
    q_cmd.ch       = ch;
    q_cmd.canon    = canonical_mode;
    q_cmd.echo_en  = echo_enable;
    q_cmd.echo_ctl = echo_enable & echo_ctl;
    q_cmd.flush    = ~noflush_on_intr;
    priority if (op == OP_POP) begin
      q_cmd.kind = CMD_POP;
    end else if (isig_enable && ch == intr_char) begin
      q_cmd.kind = CMD_INTR;
    end else if (canonical_mode && (ch == CH_BS || ch == erase_char)) begin
      q_cmd.kind = CMD_ERASE;
    end else begin
      q_cmd.kind = CMD_CHAR;
    end
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

endmodule

`default_nettype wire

/* hdl/cld_cmdq.sv */
// cld_cmdq: short command queue between the front and the back
// depends on cld_pkg
`default_nettype none

module cld_cmdq import cld_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      push_ready,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      pop_valid
);

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != CMDQ_CW'(CMDQ_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/cld_back.sv */
// cld_back: line store, input ring, line commit copy and result words
// depends on cld_pkg; takes commands from cld_cmdq
`default_nettype none

module cld_back import cld_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      cmd_in,
  input  wire logic cmd_valid,
  output logic      cmd_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic       echo_valid,
  output logic [7:0] echo_char,
  output logic       intr_raised,
  output logic       data_ready,
  output logic       read_valid,
  output logic [7:0] read_char,
  output logic       last_result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_COPY = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t st, st_next;
  cmd_t   cmd;

  // stores
  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] ring_rd_q;
  logic [7:0] line_rd_q;

  logic [RING_AW-1:0] head, head_next;
  logic [RING_AW-1:0] tail, tail_next;
  logic [RING_CW-1:0] count, count_next;
  logic [LINE_AW-1:0] line_length, line_length_next;

  // commit copy
  logic [LINE_CW-1:0] copy_cnt, copy_cnt_next;
  logic [LINE_CW-1:0] copy_len, copy_len_next;
  logic               pend, pend_next;
  logic               copy_issue;

  // result description
  echo_kind_t ekind, ekind_next;
  logic [1:0] res_last, res_last_next;
  logic [1:0] res_idx, res_idx_next;
  logic       flag_intr, flag_intr_next;
  logic       flag_ready, flag_ready_next;
  logic       flag_rv, flag_rv_next;

  // memory port controls
  logic       push_en;
  logic [7:0] push_data;
  logic       ring_wr;
  logic       ring_rd;
  logic       line_wr;
  logic       out_load;

  assign cmd_pop    = (st == ST_IDLE) && cmd_valid;
  assign copy_issue = (copy_cnt != copy_len);
  assign ring_wr    = push_en && (count != RING_CW'(RING_DEPTH));
  assign ring_rd    = (st == ST_EXEC) && (cmd.kind == CMD_POP) && (count != '0);
  assign line_wr    = (st == ST_EXEC) && (cmd.kind == CMD_CHAR) && cmd.canon;
  assign out_load   = (st == ST_EMIT) && (!out_valid || out_ready);

  // ring memory
  always_ff @(posedge clk) begin
    if (ring_wr) begin
      ring_mem[head] <= push_data;
    end
    if (ring_rd) begin
      ring_rd_q <= ring_mem[tail];
    end
  end

  // line memory
  always_ff @(posedge clk) begin
    if (line_wr) begin
      line_mem[line_length] <= cmd.ch;
    end
    if ((st == ST_COPY) && copy_issue) begin
      line_rd_q <= line_mem[copy_cnt[LINE_AW-1:0]];
    end
  end

  // sequencer
  always_comb begin
    st_next          = st;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    line_length_next = line_length;
    copy_cnt_next    = copy_cnt;
    copy_len_next    = copy_len;
    pend_next        = pend;
    ekind_next       = ekind;
    res_last_next    = res_last;
    res_idx_next     = res_idx;
    flag_intr_next   = flag_intr;
    flag_ready_next  = flag_ready;
    flag_rv_next     = flag_rv;
    push_en          = 1'b0;
    push_data        = cmd.ch;

    unique case (st)
      ST_IDLE: begin
        if (cmd_valid) begin
          st_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        ekind_next      = ECHO_NONE;
        res_last_next   = 2'd0;
        res_idx_next    = 2'd0;
        flag_intr_next  = 1'b0;
        flag_ready_next = 1'b0;
        flag_rv_next    = 1'b0;
        st_next         = ST_EMIT;
        unique case (cmd.kind)
          CMD_POP: begin
            if (count != '0) begin
              tail_next    = (tail == RING_AW'(RING_DEPTH - 1)) ? '0 : tail + 1'b1;
              count_next   = count - 1'b1;
              flag_rv_next = 1'b1;
            end
          end
          CMD_INTR: begin
            flag_intr_next = 1'b1;
            if (cmd.flush) begin
              head_next        = '0;
              tail_next        = '0;
              count_next       = '0;
              line_length_next = '0;
            end
            if (cmd.echo_ctl) begin
              ekind_next    = ECHO_INTR;
              res_last_next = 2'd3;
            end
          end
          CMD_ERASE: begin
            if (line_length != '0) begin
              line_length_next = line_length - 1'b1;
              if (cmd.echo_en) begin
                ekind_next    = ECHO_ERASE;
                res_last_next = 2'd2;
              end
            end
          end
          CMD_CHAR: begin
            if (cmd.canon) begin
              if (cmd.ch == CH_LF || line_length == LINE_AW'(LINE_DEPTH - 1)) begin
                copy_len_next    = LINE_CW'(line_length) + 1'b1;
                copy_cnt_next    = '0;
                pend_next        = 1'b0;
                line_length_next = '0;
                flag_ready_next  = 1'b1;
                st_next          = ST_COPY;
              end else begin
                line_length_next = line_length + 1'b1;
              end
            end else begin
              push_en         = 1'b1;
              flag_ready_next = 1'b1;
            end
            if (cmd.echo_en && cmd.ch != CH_NUL) begin
              if (cmd.ch == CH_LF) begin
                ekind_next    = ECHO_CRLF;
                res_last_next = 2'd1;
              end else begin
                ekind_next    = ECHO_SINGLE;
                res_last_next = 2'd0;
              end
            end
          end
        endcase
      end

      ST_COPY: begin
        // one read issued and one byte pushed per cycle
        push_en   = pend;
        push_data = line_rd_q;
        pend_next = copy_issue;
        if (copy_issue) begin
          copy_cnt_next = copy_cnt + 1'b1;
        end else if (!pend) begin
          st_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_load) begin
          if (res_idx == res_last) begin
            st_next = ST_IDLE;
          end else begin
            res_idx_next = res_idx + 1'b1;
          end
        end
      end

      default: st_next = ST_IDLE;
    endcase

    // ring push, dropped when full
    if (ring_wr) begin
      head_next  = (head == RING_AW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
      count_next = count + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      line_length <= '0;
      pend        <= 1'b0;
      copy_cnt    <= '0;
      copy_len    <= '0;
      res_idx     <= '0;
      res_last    <= '0;
      out_valid   <= 1'b0;
    end else begin
      st          <= st_next;
      head        <= head_next;
      tail        <= tail_next;
      count       <= count_next;
      line_length <= line_length_next;
      pend        <= pend_next;
      copy_cnt    <= copy_cnt_next;
      copy_len    <= copy_len_next;
      res_idx     <= res_idx_next;
      res_last    <= res_last_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command and result description
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd <= cmd_in;
    end
    ekind      <= ekind_next;
    flag_intr  <= flag_intr_next;
    flag_ready <= flag_ready_next;
    flag_rv    <= flag_rv_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      echo_valid  <= (ekind != ECHO_NONE);
      echo_char   <= echo_byte(ekind, res_idx, cmd.ch);
      intr_raised <= flag_intr;
      data_ready  <= flag_ready;
      read_valid  <= flag_rv;
      read_char   <= flag_rv ? ring_rd_q : 8'h00;
      last_result <= (res_idx == res_last);
    end
  end

endmodule

`default_nettype wire

/* hdl/canonical_line_discipline.sv */
// Terminal input line editor with an input ring. Every input word is classified by
// the front (receive, interrupt, erase or pop) and queued in a two-entry command
// queue, so a new word can be taken while the back is still working or while a result
// waits at the output register. The back handles one word at a time: it goes from its
// idle state through an execute state to an emit state, which loads one result word
// (one to four results) into the output register whenever out_ready allows. A word
// that commits a line also passes through a copy state, because the single-port line
// memory is copied into the ring memory one byte per cycle. Configuration writes are
// taken in any cycle and must only be issued while the block is idle.
// depends on cld_pkg, cld_front, cld_cmdq, cld_back
`default_nettype none

module canonical_line_discipline import cld_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [7:0] rx_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            echo_valid,
  output logic [7:0]      echo_char,
  output logic            intr_raised,
  output logic            data_ready,
  output logic            read_valid,
  output logic [7:0]      read_char,
  output logic            last_result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic q_push;
  logic q_ready;
  cmd_t q_cmd;
  cmd_t b_cmd;
  logic b_valid;
  logic b_pop;

  // accept and classify
  cld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .rx_char   (rx_char),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_ready   (q_ready)
  );

  // command queue
  cld_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .push_ready (q_ready),
    .pop        (b_pop),
    .pop_cmd    (b_cmd),
    .pop_valid  (b_valid)
  );

  // execution and results
  cld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_in      (b_cmd),
    .cmd_valid   (b_valid),
    .cmd_pop     (b_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .echo_valid  (echo_valid),
    .echo_char   (echo_char),
    .intr_raised (intr_raised),
    .data_ready  (data_ready),
    .read_valid  (read_valid),
    .read_char   (read_char),
    .last_result (last_result)
  );

endmodule

`default_nettype wire
